FILE: src/cfr_pkg.sv
package cfr_pkg;

   localparam int FRAME_LEN_DEFAULT = 8;

   localparam logic [7:0] HEAD_CONNECT = 8'h05;
   localparam logic [7:0] HEAD_SET     = 8'h55;
   localparam logic [7:0] HEAD_READ    = 8'hAA;

   // Reply frame: only these positions can be nonzero, the rest are zero fill.
   typedef struct packed {
      logic [7:0] head;
      logic [7:0] stype;
      logic [7:0] id_hi;
      logic [7:0] id_lo;
      logic [7:0] chk;
   } reply_type;

   typedef struct packed {
      logic send;
      logic save;
   } verdict_type;

endpackage

FILE: src/cfr_reply.sv
module cfr_reply #(
   parameter int FRAME_LEN = cfr_pkg::FRAME_LEN_DEFAULT
) (
   input  logic [7:0]          frame [FRAME_LEN],
   input  logic [7:0]          stored_stype,
   input  logic [15:0]         node_id,
   output cfr_pkg::verdict_type verdict,
   output cfr_pkg::reply_type   reply
);

   logic [7:0] frame_xor;
   logic       chk_ok;

   always_comb begin
      frame_xor = 8'h00;
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
         frame_xor = frame_xor ^ frame[i];
      end
   end

   assign chk_ok = (frame_xor == frame[FRAME_LEN-1]);

   always_comb begin
      verdict = '0;
      reply   = '0;
      reply.head = frame[0];
      unique case (frame[0])
         cfr_pkg::HEAD_CONNECT: begin
            verdict.send = chk_ok;
         end
         cfr_pkg::HEAD_SET: begin
            verdict.send = chk_ok;
            verdict.save = chk_ok;
            // echo the values being stored
            reply.stype = frame[1];
            reply.id_hi = frame[2];
            reply.id_lo = frame[3];
         end
         cfr_pkg::HEAD_READ: begin
            verdict.send = chk_ok;
            reply.stype  = stored_stype;
            reply.id_hi  = node_id[15:8];
            reply.id_lo  = node_id[7:0];
         end
         default: begin
            verdict = '0;
         end
      endcase
      reply.chk = reply.head ^ reply.stype ^ reply.id_hi ^ reply.id_lo;
   end

endmodule

FILE: src/config_frame_responder.sv
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_rx_byte, req_burst_end
// rsp      out        rsp_valid, rsp_ready, rsp_tx_byte, rsp_reply_last, rsp_save_request
//
// A byte without burst end is taken in every cycle. A burst end is held off while
// a reply drains or a frame is checked; the frame is checked in the cycle after it
// and, if its head is known and its checksum matches, a reply of FRAME_LEN bytes
// leaves one per cycle while rsp_ready is high. Reset is synchronous and clears the
// stored type and identifier; a stalled rsp holds its byte.
module config_frame_responder #(
   parameter int FRAME_LEN = cfr_pkg::FRAME_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       req_burst_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_reply_last,
   output logic       rsp_save_request
);

   localparam int CNT_W = $clog2(FRAME_LEN + 1);
   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

   logic [7:0]       frame_ff [FRAME_LEN];
   logic [7:0]       frame_in [FRAME_LEN];
   logic [7:0]       frame_view [FRAME_LEN];
   logic [CNT_W-1:0] count_ff, count_in, count_base;
   logic             eval_ff, eval_in;
   logic [7:0]       stype_ff, stype_in;
   logic [15:0]      node_id_ff, node_id_in;
   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             save_ff, save_in;
   cfr_pkg::reply_type   reply_ff, reply_in, reply_new;
   cfr_pkg::verdict_type verdict;
   logic             req_fire, rsp_fire;

   assign req_ready = !(req_burst_end && (eval_ff || busy_ff));
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = busy_ff && rsp_ready;

   // Positions not yet received read as zero.
   always_comb begin
      for (int i = 0; i < FRAME_LEN; i++) begin
         frame_view[i] = (CNT_W'(i) < count_ff) ? frame_ff[i] : 8'h00;
      end
   end

   cfr_reply #(.FRAME_LEN(FRAME_LEN)) u_reply (
      .frame        (frame_view),
      .stored_stype (stype_ff),
      .node_id      (node_id_ff),
      .verdict      (verdict),
      .reply        (reply_new)
   );

   always_comb begin
      // drop the finished frame in the check cycle
      count_base = eval_ff ? '0 : count_ff;
      count_in   = count_base;
      frame_in   = frame_ff;
      if (req_fire && (count_base < CNT_W'(FRAME_LEN))) begin
         frame_in[count_base[IDX_W-1:0]] = req_rx_byte;
         count_in = count_base + CNT_W'(1);
      end
      eval_in = req_fire && req_burst_end;
   end

   always_comb begin
      stype_in   = stype_ff;
      node_id_in = node_id_ff;
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      save_in    = save_ff;
      reply_in   = reply_ff;
      if (rsp_fire) begin
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end
      if (eval_ff && verdict.send) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         save_in  = verdict.save;
         reply_in = reply_new;
         if (verdict.save) begin
            stype_in   = reply_new.stype;
            node_id_in = {reply_new.id_hi, reply_new.id_lo};
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      reply_ff <= reply_in;
      save_ff  <= save_in;
      if (reset) begin
         count_ff   <= '0;
         eval_ff    <= 1'b0;
         stype_ff   <= 8'h00;
         node_id_ff <= 16'h0000;
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         count_ff   <= count_in;
         eval_ff    <= eval_in;
         stype_ff   <= stype_in;
         node_id_ff <= node_id_in;
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
      end
   end

   always_comb begin
      if (idx_ff == '0) begin
         rsp_tx_byte = reply_ff.head;
      end else if (idx_ff == IDX_W'(1)) begin
         rsp_tx_byte = reply_ff.stype;
      end else if (idx_ff == IDX_W'(2)) begin
         rsp_tx_byte = reply_ff.id_hi;
      end else if (idx_ff == IDX_W'(3)) begin
         rsp_tx_byte = reply_ff.id_lo;
      end else if (idx_ff == LAST_IDX) begin
         rsp_tx_byte = reply_ff.chk;
      end else begin
         rsp_tx_byte = 8'h00;
      end
   end

   assign rsp_valid        = busy_ff;
   assign rsp_reply_last   = (idx_ff == LAST_IDX);
   assign rsp_save_request = save_ff;

endmodule

FILE: src/cfr_checker.sv
module cfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_burst_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_reply_last,
   input logic       rsp_save_request
);

   // a stalled reply byte holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("rsp byte changed under stall");

   // reply bytes leave without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_reply_last |=> rsp_valid)
      else $error("gap inside reply");

   // the save flag covers a whole reply
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_reply_last |=> $stable(rsp_save_request))
      else $error("save flag changed inside reply");

   // replies never run back to back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_reply_last |=> !rsp_valid)
      else $error("reply started right after the last byte");

   // a burst end is taken only with the reply side empty, and it stays empty
   // through the check cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_burst_end |-> !rsp_valid ##1 !rsp_valid)
      else $error("burst end taken while a reply was pending");

endmodule

bind config_frame_responder cfr_checker u_cfr_checker (.*);
